// File: rtl/kalman_angle_bias_filter_top_defines.svh
// Assertion macros used by the filter RTL.
`ifndef KALMAN_ANGLE_BIAS_FILTER_TOP_DEFINES_SVH
`define KALMAN_ANGLE_BIAS_FILTER_TOP_DEFINES_SVH

// Clocked property check that is suspended while reset is high.
`define KABF_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked property check that also holds during reset.
`define KABF_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: rtl/kabf_pkg.sv
// Types, constants and arithmetic helpers of the angle and bias filter.
`default_nettype none
package kabf_pkg;
   localparam int unsigned DivSteps = 31;
   localparam logic [15:0] StepTimeMax = 16'd32768;
   localparam logic [30:0] AngleNoiseReset = 31'd1073742;
   localparam logic [30:0] BiasNoiseReset = 31'd3221225;
   localparam logic [30:0] MeasNoiseReset = 31'd32212255;
   localparam logic [1:0] CsrAngleNoise = 2'd0;
   localparam logic [1:0] CsrBiasNoise = 2'd1;
   localparam logic [1:0] CsrMeasNoise = 2'd2;
   localparam logic signed [67:0] SatMax = 68'sh0_7FFF_FFFF;
   localparam logic signed [67:0] SatMin = -68'sh0_8000_0000;

   typedef enum logic [16:0] {
      ST_IDLE = 17'h00001,
      ST_M0   = 17'h00002,
      ST_M1   = 17'h00004,
      ST_M2   = 17'h00008,
      ST_M3   = 17'h00010,
      ST_M4   = 17'h00020,
      ST_D0   = 17'h00040,
      ST_W0   = 17'h00080,
      ST_W1   = 17'h00100,
      ST_C0   = 17'h00200,
      ST_C1   = 17'h00400,
      ST_C2   = 17'h00800,
      ST_C3   = 17'h01000,
      ST_C4   = 17'h02000,
      ST_C5   = 17'h04000,
      ST_C6   = 17'h08000,
      ST_OUT  = 17'h10000
   } state_type;

   typedef struct packed {
      logic              done;
      logic signed [31:0] quot;
   } div_result_type;

   function automatic logic signed [67:0] round_shift(input logic signed [67:0] p,
                                                      input logic by30);
      logic signed [67:0] half;
      half = by30 ? (68'sd1 <<< 29) : (68'sd1 <<< 15);
      return by30 ? ((p + half) >>> 30) : ((p + half) >>> 16);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
      logic signed [31:0] r;
      if (v > SatMax) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < SatMin) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction
endpackage
`default_nettype wire

// File: rtl/kabf_if.sv
// Request and response channel interfaces of the angle and bias filter.
`default_nettype none
interface kabf_req_if;
   logic              valid;
   logic              ready;
   logic signed [24:0] measured_angle;
   logic signed [24:0] measured_rate;
   logic [15:0]       step_time;
   logic              force_angle;
   modport source (output valid, measured_angle, measured_rate, step_time, force_angle,
                   input ready);
   modport sink (input valid, measured_angle, measured_rate, step_time, force_angle,
                 output ready);
endinterface

interface kabf_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [31:0] filtered_angle;
   logic signed [31:0] bias_estimate_out;
   modport source (output valid, filtered_angle, bias_estimate_out, input ready);
   modport sink (input valid, filtered_angle, bias_estimate_out, output ready);
endinterface
`default_nettype wire

// File: rtl/kalman_angle_bias_filter_top.sv
// Top level of the two-state angle and gyro bias filter.
// One request is taken at a time. Its response comes sooner when both gains are zero or
// saturated than when they need the full 31-step division. Four multiplies and one
// accumulate step predict the state, each 31-step radix-2 division holds the sequencer
// until the divider is done, and six multiplies correct the state, all on one shared
// 34 by 34 bit multiplier and one divider. The next request is taken as soon as the
// sequencer is back in idle, while the previous response may still wait.
`default_nettype none
`include "kalman_angle_bias_filter_top_defines.svh"
module kalman_angle_bias_filter_top
   import kabf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   kabf_req_if.sink         req_chan,
   kabf_rsp_if.source       rsp_chan,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [30:0] csr_data
);
   state_type          state_ff, state_in;
   logic [30:0]        qa_ff, qb_ff, r_ff;
   logic signed [31:0] angle_ff, angle_in, bias_ff, bias_in;
   logic signed [31:0] p00_ff, p00_in, p01_ff, p01_in, p10_ff, p10_in, p11_ff, p11_in;
   logic signed [24:0] meas_ff, meas_in, rate_ff, rate_in;
   logic [15:0]        d_ff, d_in;
   logic signed [31:0] a_ff, a_in, y_ff, y_in;
   logic signed [33:0] t_ff, t_in;
   logic signed [31:0] n00_ff, n00_in, n01_ff, n01_in, n10_ff, n10_in, n11_ff, n11_in;
   logic signed [31:0] k0_ff, k0_in, k1_ff, k1_in;
   logic signed [67:0] prod_ff;
   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] r16, r30;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_angle_ff, rsp_angle_in, rsp_bias_ff, rsp_bias_in;
   logic               div_start;
   logic signed [31:0] div_numer;
   logic signed [33:0] div_denom;
   div_result_type     div_res;
   logic               req_fire;

   kabf_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .numer  (div_numer),
      .denom  (div_denom),
      .result (div_res)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.filtered_angle = rsp_angle_ff;
   assign rsp_chan.bias_estimate_out = rsp_bias_ff;

   always_comb begin
      r16 = round_shift(prod_ff, 1'b0);
      r30 = round_shift(prod_ff, 1'b1);
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_M0: begin
            mul_a = 34'($signed({1'b0, d_ff}));
            mul_b = 34'(rate_ff) - 34'(bias_ff);
         end
         ST_M1: begin
            mul_a = 34'($signed({1'b0, d_ff}));
            mul_b = 34'(p11_ff);
         end
         ST_M2: begin
            mul_a = 34'($signed({1'b0, d_ff}));
            mul_b = 34'($signed({1'b0, qb_ff}));
         end
         ST_M3: begin
            mul_a = 34'($signed({1'b0, d_ff}));
            mul_b = t_ff - 34'(p01_ff) - 34'(p10_ff) + 34'($signed({1'b0, qa_ff}));
         end
         ST_C0: begin
            mul_a = 34'(k0_ff);
            mul_b = 34'(y_ff);
         end
         ST_C1: begin
            mul_a = 34'(k1_ff);
            mul_b = 34'(y_ff);
         end
         ST_C2: begin
            mul_a = 34'(k0_ff);
            mul_b = 34'(n00_ff);
         end
         ST_C3: begin
            mul_a = 34'(k0_ff);
            mul_b = 34'(n01_ff);
         end
         ST_C4: begin
            mul_a = 34'(k1_ff);
            mul_b = 34'(n00_ff);
         end
         ST_C5: begin
            mul_a = 34'(k1_ff);
            mul_b = 34'(n01_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      angle_in = angle_ff;
      bias_in = bias_ff;
      p00_in = p00_ff;
      p01_in = p01_ff;
      p10_in = p10_ff;
      p11_in = p11_ff;
      meas_in = meas_ff;
      rate_in = rate_ff;
      d_in = d_ff;
      a_in = a_ff;
      y_in = y_ff;
      t_in = t_ff;
      n00_in = n00_ff;
      n01_in = n01_ff;
      n10_in = n10_ff;
      n11_in = n11_ff;
      k0_in = k0_ff;
      k1_in = k1_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_angle_in = rsp_angle_ff;
      rsp_bias_in = rsp_bias_ff;
      div_start = 1'b0;
      div_numer = n00_ff;
      div_denom = 34'(n00_ff) + 34'($signed({1'b0, r_ff}));
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               meas_in = req_chan.measured_angle;
               rate_in = req_chan.measured_rate;
               d_in = (req_chan.step_time > StepTimeMax) ? StepTimeMax : req_chan.step_time;
               if (req_chan.force_angle) begin
                  angle_in = 32'(req_chan.measured_angle);
               end
               state_in = ST_M0;
            end
         end
         ST_M0: state_in = ST_M1;
         ST_M1: begin
            a_in = sat32(68'(angle_ff) + r16);
            state_in = ST_M2;
         end
         ST_M2: begin
            t_in = 34'(r16);
            n01_in = sat32(68'(p01_ff) - r16);
            n10_in = sat32(68'(p10_ff) - r16);
            state_in = ST_M3;
         end
         ST_M3: begin
            n11_in = sat32(68'(p11_ff) + r16);
            y_in = sat32(68'(meas_ff) - 68'(a_ff));
            state_in = ST_M4;
         end
         ST_M4: begin
            n00_in = sat32(68'(p00_ff) + r16);
            state_in = ST_D0;
         end
         ST_D0: begin
            div_start = 1'b1;
            state_in = ST_W0;
         end
         ST_W0: begin
            if (div_res.done) begin
               k0_in = div_res.quot;
               div_start = 1'b1;
               div_numer = n10_ff;
               state_in = ST_W1;
            end
         end
         ST_W1: begin
            if (div_res.done) begin
               k1_in = div_res.quot;
               state_in = ST_C0;
            end
         end
         ST_C0: state_in = ST_C1;
         ST_C1: begin
            angle_in = sat32(68'(a_ff) + r30);
            state_in = ST_C2;
         end
         ST_C2: begin
            bias_in = sat32(68'(bias_ff) + r30);
            state_in = ST_C3;
         end
         ST_C3: begin
            p00_in = sat32(68'(n00_ff) - r30);
            state_in = ST_C4;
         end
         ST_C4: begin
            p01_in = sat32(68'(n01_ff) - r30);
            state_in = ST_C5;
         end
         ST_C5: begin
            p10_in = sat32(68'(n10_ff) - r30);
            state_in = ST_C6;
         end
         ST_C6: begin
            p11_in = sat32(68'(n11_ff) - r30);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_angle_in = angle_ff;
               rsp_bias_in = bias_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         angle_ff <= '0;
         bias_ff <= '0;
         p00_ff <= '0;
         p01_ff <= '0;
         p10_ff <= '0;
         p11_ff <= '0;
         qa_ff <= AngleNoiseReset;
         qb_ff <= BiasNoiseReset;
         r_ff <= MeasNoiseReset;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         angle_ff <= angle_in;
         bias_ff <= bias_in;
         p00_ff <= p00_in;
         p01_ff <= p01_in;
         p10_ff <= p10_in;
         p11_ff <= p11_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CsrAngleNoise: qa_ff <= csr_data;
               CsrBiasNoise:  qb_ff <= csr_data;
               CsrMeasNoise:  r_ff <= csr_data;
               default: ;
            endcase
         end
      end
      meas_ff <= meas_in;
      rate_ff <= rate_in;
      d_ff <= d_in;
      a_ff <= a_in;
      y_ff <= y_in;
      t_ff <= t_in;
      n00_ff <= n00_in;
      n01_ff <= n01_in;
      n10_ff <= n10_in;
      n11_ff <= n11_in;
      k0_ff <= k0_in;
      k1_ff <= k1_in;
      prod_ff <= mul_a * mul_b;
      rsp_angle_ff <= rsp_angle_in;
      rsp_bias_ff <= rsp_bias_in;
   end

   `KABF_ASSERT(a_req_starts_predict, req_fire |=> (state_ff == ST_M0), "request did not start")
   `KABF_ASSERT(a_div_done_in_wait, div_res.done |-> (state_ff == ST_W0 || state_ff == ST_W1),
                "divider finished outside a wait state")
   `KABF_ASSERT(a_rsp_from_out, $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_OUT),
                "response raised outside the output step")
endmodule
`default_nettype wire

// File: rtl/kabf_div.sv
// Radix-2 restoring divider that forms a saturated Q2.30 gain.
`default_nettype none
module kabf_div
   import kabf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [31:0] numer,
   input  wire logic signed [33:0] denom,
   output div_result_type          result
);
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [31:0]        rem_ff, rem_in;
   logic [30:0]        q_ff, q_in;
   logic [32:0]        s_ff, s_in;
   logic               neg_ff, neg_in;
   logic               lsb_ff, lsb_in;
   logic signed [31:0] quot_ff, quot_in;
   logic [31:0]        mag;
   logic [32:0]        trial;
   logic               ge;
   logic [30:0]        q_next;

   always_comb begin
      mag = numer[31] ? (~numer + 32'd1) : numer;
      trial = {rem_ff, (cnt_ff == 5'd0) ? lsb_ff : 1'b0};
      ge = trial >= s_ff;
      q_next = {q_ff[29:0], ge};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      q_in = q_ff;
      s_in = s_ff;
      neg_in = neg_ff;
      lsb_in = lsb_ff;
      quot_in = quot_ff;
      if (busy_ff) begin
         rem_in = ge ? 32'(trial - s_ff) : trial[31:0];
         q_in = q_next;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(DivSteps - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            quot_in = neg_ff ? -$signed({1'b0, q_next}) : $signed({1'b0, q_next});
         end
      end else if (start) begin
         neg_in = numer[31];
         s_in = denom[32:0];
         if (denom[33] || (denom == 34'sd0)) begin
            done_in = 1'b1;
            quot_in = 32'sd0;
         end else if ({2'b00, mag} >= {denom[32:0], 1'b0}) begin
            done_in = 1'b1;
            quot_in = numer[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         end else begin
            busy_in = 1'b1;
            cnt_in = 5'd0;
            rem_in = {1'b0, mag[31:1]};
            lsb_in = mag[0];
            q_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      q_ff <= q_in;
      s_ff <= s_in;
      neg_ff <= neg_in;
      lsb_ff <= lsb_in;
      quot_ff <= quot_in;
   end

   assign result.done = done_ff;
   assign result.quot = quot_ff;
endmodule
`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking testbench for the two-state angle and gyro bias filter.
module tb;
   import kabf_pkg::*;

   localparam logic [1:0] CsrUnused = 2'd3;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [1:0] csr_index;
   logic [30:0] csr_data;

   kabf_req_if req_chan();
   kabf_rsp_if rsp_chan();

   kalman_angle_bias_filter_top dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   typedef struct packed {
      logic signed [24:0] angle;
      logic signed [24:0] rate;
      logic [15:0] dt;
      logic force_angle;
   } request_type;

   typedef struct packed {
      logic signed [31:0] angle;
      logic signed [31:0] bias;
   } estimate_type;

   typedef struct {
      request_type req;
      logic typed_in;
      estimate_type want;
   } stimulus_row_type;

   logic [30:0] q_angle, q_bias, r_meas;
   longint est_angle, est_bias;
   longint cov [4];
   estimate_type expected_estimates [$];
   int errors = 0;
   int rsp_count = 0;
   int unsigned cycle_count = 0;
   logic idle_allowed = 1'b1;
   logic hold_rsp = 1'b0;
   int hold_cycles = 0;
   int hold_len = 0;
   stimulus_row_type directed [$];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint round_by(longint v, int n);
      return (v + (64'sd1 <<< (n - 1))) >>> n;
   endfunction

   // Widen to 128 bits where products can exceed 64 bits.
   function automatic longint round_prod(longint a, longint b, int n);
      logic signed [127:0] p;
      p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
      p = (p + (128'sd1 <<< (n - 1))) >>> n;
      return p[63:0];
   endfunction

   function automatic estimate_type filter_update(request_type rq);
      longint meas, rate, d, a, t, n00, n01, n10, n11, s, k0, k1, y;
      estimate_type e;
      meas = rq.angle;
      rate = rq.rate;
      d = rq.dt;
      k0 = 0;
      k1 = 0;
      if (d > 32768) d = 32768;
      if (rq.force_angle) est_angle = meas;
      a = clamp32(est_angle + round_by(d * (rate - est_bias), 16));
      t = round_by(d * cov[3], 16);
      n00 = clamp32(cov[0] + round_prod(d, t - cov[1] - cov[2] + longint'(q_angle), 16));
      n01 = clamp32(cov[1] - t);
      n10 = clamp32(cov[2] - t);
      n11 = clamp32(cov[3] + round_by(longint'(q_bias) * d, 16));
      s = n00 + longint'(r_meas);
      if (s > 0) begin
         k0 = clamp32((n00 * (64'sd1 <<< 30)) / s);
         k1 = clamp32((n10 * (64'sd1 <<< 30)) / s);
      end
      y = clamp32(meas - a);
      est_angle = clamp32(a + round_prod(k0, y, 30));
      est_bias = clamp32(est_bias + round_prod(k1, y, 30));
      cov[0] = clamp32(n00 - round_prod(k0, n00, 30));
      cov[1] = clamp32(n01 - round_prod(k0, n01, 30));
      cov[2] = clamp32(n10 - round_prod(k1, n00, 30));
      cov[3] = clamp32(n11 - round_prod(k1, n01, 30));
      e.angle = est_angle[31:0];
      e.bias = est_bias[31:0];
      return e;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch in %s at response %0d: got %0d expected %0d",
               what, rsp_count, got, want);
      errors++;
   endtask

   task automatic write_register(logic [1:0] idx, logic [30:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CsrAngleNoise) q_angle = value;
      else if (idx == CsrBiasNoise) q_bias = value;
      else if (idx == CsrMeasNoise) r_meas = value;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (expected_estimates.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic send_request(request_type rq, logic typed_in, estimate_type want);
      estimate_type e;
      if (idle_allowed && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.measured_angle <= rq.angle;
      req_chan.measured_rate <= rq.rate;
      req_chan.step_time <= rq.dt;
      req_chan.force_angle <= rq.force_angle;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      e = filter_update(rq);
      if (typed_in && e !== want)
         report_mismatch("directed prediction", e, want);
      expected_estimates.push_back(e);
   endtask

   function automatic request_type random_request(int mode);
      request_type rq;
      rq.angle = 25'($urandom_range(0, 23592960) - 11796480);
      rq.rate = 25'($urandom_range(0, 33554431) - 16777216);
      rq.force_angle = ($urandom_range(0, 9) == 0);
      case (mode)
         0: rq.dt = 16'($urandom_range(0, 65535));
         1: rq.dt = 16'($urandom_range(0, 32768));
         default: rq.dt = 16'($urandom_range(0, 700));
      endcase
      if (mode == 2) rq.rate = $signed(rq.rate) >>> $urandom_range(0, 12);
      return rq;
   endfunction

   function automatic stimulus_row_type row(int a, int r, int d, bit f, bit typed,
                                            int wa, int wb);
      stimulus_row_type s;
      s.req.angle = 25'(a);
      s.req.rate = 25'(r);
      s.req.dt = 16'(d);
      s.req.force_angle = f;
      s.typed_in = typed;
      s.want.angle = wa;
      s.want.bias = wb;
      return s;
   endfunction

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 3000000) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      estimate_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_count++;
            if (expected_estimates.size() == 0) begin
               report_mismatch("unexpected response", rsp_chan.filtered_angle, 0);
            end else begin
               want = expected_estimates.pop_front();
               if (rsp_chan.filtered_angle !== want.angle)
                  report_mismatch("filtered_angle", rsp_chan.filtered_angle, want.angle);
               if (rsp_chan.bias_estimate_out !== want.bias)
                  report_mismatch("bias_estimate_out", rsp_chan.bias_estimate_out,
                                  want.bias);
            end
         end
         if (hold_rsp) begin
            rsp_chan.ready <= 1'b0;
         end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_chan.ready <= 1'b0;
         end else if (idle_allowed && $urandom_range(0, 6) == 0) begin
            hold_cycles <= $urandom_range(0, 4);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Long receiver stall counted in cycles while the sender keeps offering.
   always @(posedge clock) begin
      if (hold_len > 0) begin
         hold_rsp <= 1'b1;
         hold_len <= hold_len - 1;
      end else begin
         hold_rsp <= 1'b0;
      end
   end

   initial begin
      request_type rq;
      estimate_type none;
      none = '0;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_chan.valid = 1'b0;
      req_chan.measured_angle = '0;
      req_chan.measured_rate = '0;
      req_chan.step_time = '0;
      req_chan.force_angle = 1'b0;
      q_angle = AngleNoiseReset;
      q_bias = BiasNoiseReset;
      r_meas = MeasNoiseReset;
      est_angle = 0;
      est_bias = 0;
      foreach (cov[i]) cov[i] = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // From reset with a zero step the covariance stays zero, so the gains are zero.
      directed.push_back(row(0, 0, 0, 0, 1, 0, 0));
      directed.push_back(row(11796480, 0, 0, 1, 1, 11796480, 0));
      directed.push_back(row(-11796480, 0, 0, 1, 1, -11796480, 0));
      directed.push_back(row(0, 16777215, 32768, 0, 0, 0, 0));
      directed.push_back(row(0, -16777216, 65535, 0, 0, 0, 0));
      directed.push_back(row(11796480, 16777215, 65535, 0, 0, 0, 0));
      directed.push_back(row(-11796480, -16777216, 32769, 0, 0, 0, 0));
      directed.push_back(row(5000, 300, 1, 1, 0, 0, 0));
      directed.push_back(row(-1, -1, 655, 0, 0, 0, 0));
      directed.push_back(row(12345, 999, 6554, 0, 0, 0, 0));
      foreach (directed[i]) send_request(directed[i].req, directed[i].typed_in,
                                         directed[i].want);
      wait_drained();

      // Zero measurement noise and extreme process noise push the gains to their limits.
      write_register(CsrMeasNoise, 31'd0);
      write_register(CsrAngleNoise, 31'h7FFF_FFFF);
      write_register(CsrBiasNoise, 31'h7FFF_FFFF);
      write_register(CsrUnused, 31'h1234_5678);
      for (int i = 0; i < 15; i++) send_request(random_request(i % 3), 1'b0, none);
      wait_drained();
      write_register(CsrAngleNoise, 31'd0);
      write_register(CsrBiasNoise, 31'd0);
      write_register(CsrMeasNoise, 31'd1);
      for (int i = 0; i < 10; i++) send_request(random_request(i % 3), 1'b0, none);
      wait_drained();

      for (int phase = 0; phase < 6; phase++) begin
         write_register(CsrAngleNoise,
                        31'(phase == 0 ? AngleNoiseReset : $urandom_range(0, 80000000)));
         write_register(CsrBiasNoise,
                        31'(phase == 0 ? BiasNoiseReset : $urandom_range(0, 80000000)));
         write_register(CsrMeasNoise,
                        31'(phase == 5 ? 31'h7FFF_FFFF : $urandom_range(1, 200000000)));
         if (phase == 2) hold_len <= 600;
         if (phase == 5) idle_allowed = 1'b0;
         for (int i = 0; i < 300; i++) begin
            rq = random_request($urandom_range(0, 9) == 0 ? 0 : ($urandom_range(0, 1) + 1));
            send_request(rq, 1'b0, none);
            if (phase == 3 && i == 150) wait_drained();
         end
         wait_drained();
      end

      $display("Covered reset values, forced angles, step clamping, zero and extreme noise,");
      $display("and %0d responses under random idling and a long response stall.", rsp_count);
      if (errors == 0 && expected_estimates.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
